@@ rtl/smooth_vertex_normals_defines.svh @@
// Assertion macros for the smooth vertex normals block.
`ifndef SMOOTH_VERTEX_NORMALS_DEFINES_SVH
`define SMOOTH_VERTEX_NORMALS_DEFINES_SVH

// Same-cycle implication, checked on the block clock outside reset.
`define SVN_ASSERT_NOW(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error(msg);

// Next-cycle implication, checked on the block clock outside reset.
`define SVN_ASSERT_NEXT(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

`endif

@@ rtl/svn_pkg.sv @@
// Shared types and constants of the smooth vertex normals block.
package svn_pkg;

   localparam logic [1:0] MODE_LOAD = 2'd0;
   localparam logic [1:0] MODE_TRI  = 2'd1;
   localparam logic [1:0] MODE_READ = 2'd2;

   // component width into the normalizer and magnitude width inside it
   localparam int CW = 63;
   localparam int MW = 62;

   typedef struct packed {
      logic [1:0]         mode;
      logic [9:0]         vertex_index;
      logic [9:0]         corner_b;
      logic [9:0]         corner_c;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
   } req_type;

   typedef struct packed {
      logic signed [15:0] normal_x;
      logic signed [15:0] normal_y;
      logic signed [15:0] normal_z;
      logic               zero_normal;
   } rsp_type;

   typedef struct packed {
      logic busy;
      logic done;
      logic ok;
   } unit_stat_type;

   typedef enum logic [3:0] {
      T_CLEAR,
      T_IDLE,
      T_PB,
      T_PC,
      T_PD,
      T_FSHIFT,
      T_CROSS,
      T_USTART,
      T_NWAIT,
      T_ARD,
      T_AWR,
      T_PUT
   } seq_state_type;

   typedef enum logic [2:0] {
      U_IDLE,
      U_SCAN,
      U_SQ,
      U_ROOT,
      U_DPREP,
      U_DIV
   } unit_state_type;

endpackage

@@ rtl/svn_req_if.sv @@
// Request channel: valid, ready and one request payload.
interface svn_req_if import svn_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/svn_rsp_if.sv @@
// Response channel: valid, ready and one normal payload.
interface svn_rsp_if import svn_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/svn_unit3.sv @@
// Multi-cycle normalizer of a signed 3-vector to Q1.14.
module svn_unit3 import svn_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic signed [CW-1:0] vec_x,
   input  logic signed [CW-1:0] vec_y,
   input  logic signed [CW-1:0] vec_z,
   output logic signed [15:0]   nrm_x,
   output logic signed [15:0]   nrm_y,
   output logic signed [15:0]   nrm_z,
   output unit_stat_type        stat
);

   unit_state_type     state_ff, state_in;
   logic [MW-1:0]      m_ff [3];
   logic [MW-1:0]      m_in [3];
   logic [2:0]         neg_ff, neg_in;
   logic [61:0]        s_ff, s_in;
   logic [61:0]        v_ff, v_in;
   logic [62:0]        r_ff, r_in;
   logic [62:0]        bit_ff, bit_in;
   logic [44:0]        rem_ff, rem_in;
   logic [44:0]        cand_ff, cand_in;
   logic [14:0]        q_ff, q_in;
   logic [3:0]         j_ff, j_in;
   logic [1:0]         ci_ff, ci_in;
   logic signed [15:0] n_ff [3];
   logic signed [15:0] n_in [3];
   logic               ok_ff, ok_in;
   logic               done_ff, done_in;

   logic               all_zero, any_hi, all_lo;
   logic [63:0]        trial;
   logic [59:0]        sq;
   logic [14:0]        qn;
   logic [30:0]        len;

   assign len = r_ff[30:0];

   always_comb begin : scan_flags
      all_zero = 1'b1;
      any_hi   = 1'b0;
      all_lo   = 1'b1;
      for (int i = 0; i < 3; i++) begin
         if (m_ff[i] != '0) all_zero = 1'b0;
         if (m_ff[i][MW-1:30] != '0) any_hi = 1'b1;
         if (m_ff[i][MW-1:29] != '0) all_lo = 1'b0;
      end
   end

   always_comb begin : unit_next
      state_in = state_ff;
      unique case (state_ff)
         U_IDLE:  if (start) state_in = U_SCAN;
         U_SCAN: begin
            if (all_zero) state_in = U_IDLE;
            else if (!any_hi && !all_lo) state_in = U_SQ;
         end
         U_SQ:    if (ci_ff == 2'd2) state_in = U_ROOT;
         U_ROOT:  if (bit_ff[0]) state_in = U_DPREP;
         U_DPREP: state_in = U_DIV;
         U_DIV: begin
            if (j_ff == 4'd0) state_in = (ci_ff == 2'd2) ? U_IDLE : U_DPREP;
         end
         default: state_in = U_IDLE;
      endcase
   end

   always_comb begin : unit_data
      logic signed [CW-1:0] src [3];
      m_in    = m_ff;
      neg_in  = neg_ff;
      s_in    = s_ff;
      v_in    = v_ff;
      r_in    = r_ff;
      bit_in  = bit_ff;
      rem_in  = rem_ff;
      cand_in = cand_ff;
      q_in    = q_ff;
      j_in    = j_ff;
      ci_in   = ci_ff;
      n_in    = n_ff;
      ok_in   = ok_ff;
      done_in = 1'b0;
      src[0]  = vec_x;
      src[1]  = vec_y;
      src[2]  = vec_z;
      trial   = 64'(r_ff) + 64'(bit_ff);
      sq      = m_ff[ci_ff][29:0] * m_ff[ci_ff][29:0];
      qn      = q_ff;
      unique case (state_ff)
         U_IDLE: begin
            if (start) begin
               for (int i = 0; i < 3; i++) begin
                  neg_in[i] = src[i][CW-1];
                  m_in[i]   = src[i][CW-1] ? MW'(-src[i]) : MW'(src[i]);
               end
            end
         end
         U_SCAN: begin
            if (all_zero) begin
               for (int i = 0; i < 3; i++) n_in[i] = '0;
               ok_in   = 1'b0;
               done_in = 1'b1;
            end else if (any_hi) begin
               for (int i = 0; i < 3; i++) m_in[i] = m_ff[i] >> 1;
            end else if (all_lo) begin
               for (int i = 0; i < 3; i++) m_in[i] = m_ff[i] << 1;
            end else begin
               s_in  = '0;
               ci_in = 2'd0;
            end
         end
         U_SQ: begin
            s_in  = s_ff + 62'(sq);
            ci_in = ci_ff + 2'd1;
            if (ci_ff == 2'd2) begin
               v_in   = s_ff + 62'(sq);
               r_in   = '0;
               bit_in = 63'(1) << 62;
            end
         end
         U_ROOT: begin
            // one result bit per step, two radicand bits consumed
            if (64'(v_ff) >= trial) begin
               v_in = v_ff - trial[61:0];
               r_in = (r_ff >> 1) + bit_ff;
            end else begin
               r_in = r_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            ci_in  = 2'd0;
         end
         U_DPREP: begin
            rem_in  = 45'({m_ff[ci_ff][29:0], 14'b0}) + 45'(len >> 1);
            cand_in = {len, 14'b0};
            q_in    = '0;
            j_in    = 4'd14;
         end
         U_DIV: begin
            if (rem_ff >= cand_ff) begin
               rem_in = rem_ff - cand_ff;
               qn[j_ff] = 1'b1;
            end
            q_in    = qn;
            cand_in = cand_ff >> 1;
            j_in    = j_ff - 4'd1;
            if (j_ff == 4'd0) begin
               n_in[ci_ff] = neg_ff[ci_ff] ? -16'(qn) : 16'(qn);
               ci_in = ci_ff + 2'd1;
               if (ci_ff == 2'd2) begin
                  ok_in   = 1'b1;
                  done_in = 1'b1;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= U_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      m_ff    <= m_in;
      neg_ff  <= neg_in;
      s_ff    <= s_in;
      v_ff    <= v_in;
      r_ff    <= r_in;
      bit_ff  <= bit_in;
      rem_ff  <= rem_in;
      cand_ff <= cand_in;
      q_ff    <= q_in;
      j_ff    <= j_in;
      ci_ff   <= ci_in;
      n_ff    <= n_in;
      ok_ff   <= ok_in;
   end

   assign nrm_x     = n_ff[0];
   assign nrm_y     = n_ff[1];
   assign nrm_z     = n_ff[2];
   assign stat.busy = (state_ff != U_IDLE);
   assign stat.done = done_ff;
   assign stat.ok   = ok_ff;

endmodule

@@ rtl/smooth_vertex_normals.sv @@
// Smooth vertex normals: vertex store, per-vertex normal sums, Q1.14 read-out.
// A triangle takes 3 position reads, its range shifts, 7 cross-product steps,
// the shared normalizer and, unless the face is flat, 3 read-modify-writes.
// A read is dominated by the normalizer (range shift search, 32-step square root,
// 3 divisions). One request at a time.
// Reset: synchronous; then a pass over all VERTS sums zeroes them before requests are taken.
module smooth_vertex_normals import svn_pkg::*; #(
   parameter int VERTS = 1024
) (
   input  logic      clock,
   input  logic      reset,
   svn_req_if.sink   req_if,
   svn_rsp_if.source rsp_if
);

`include "smooth_vertex_normals_defines.svh"

   localparam int AW = (VERTS > 1) ? $clog2(VERTS) : 1;
   localparam logic [2:0] CROSS_LAST = 3'd6;

   function automatic logic signed [30:0] dval(input logic [32:0] mag, input logic neg);
      logic signed [30:0] m;
      m = signed'({1'b0, mag[29:0]});
      return neg ? -m : m;
   endfunction

   function automatic logic [23:0] sat_add(input logic [23:0] acc,
                                           input logic signed [15:0] n);
      logic signed [24:0] s;
      s = 25'(signed'(acc)) + 25'(n);
      if (s[24] != s[23]) return s[24] ? 24'h800000 : 24'h7FFFFF;
      return s[23:0];
   endfunction

   // storage: positions {z, y, x}, sums {z, y, x}
   logic [95:0] pos_mem_ff [VERTS];
   logic [71:0] sum_mem_ff [VERTS];
   logic [95:0] pos_rd_ff;
   logic [71:0] sum_rd_ff;

   seq_state_type        state_ff, state_in;
   logic [AW-1:0]        clr_ff, clr_in;
   logic [AW-1:0]        a_ff, b_ff, c_ff;
   logic [AW-1:0]        a_in, b_in, c_in;
   logic                 is_read_ff, is_read_in;
   logic                 bad_ff, bad_in;
   logic [95:0]          pa_ff, pa_in;
   logic [32:0]          dmag_ff [6];
   logic [32:0]          dmag_in [6];
   logic [5:0]           dneg_ff, dneg_in;
   logic signed [61:0]   prod_ff, prod_in;
   logic signed [CW-1:0] cr_ff [3];
   logic signed [CW-1:0] cr_in [3];
   logic [2:0]           step_ff, step_in;
   logic [1:0]           k_ff, k_in;
   rsp_type              rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic          req_fire, a_ok, tri_ok, out_free, out_load, fshift_need;
   logic          pos_we, pos_re, sum_we, sum_re;
   logic [AW-1:0] pos_wa, pos_ra, sum_wa, sum_ra, corner;
   logic [71:0]   sum_wd;
   logic          ustart;
   unit_stat_type ustat;
   logic signed [15:0]   nx, ny, nz;
   logic signed [CW-1:0] ux, uy, uz;

   assign req_fire = req_if.valid && req_if.ready;
   assign a_ok     = 32'(req_if.data.vertex_index) < VERTS;
   assign tri_ok   = a_ok && (32'(req_if.data.corner_b) < VERTS)
                          && (32'(req_if.data.corner_c) < VERTS);
   assign out_free = !rsp_valid_ff || rsp_if.ready;

   always_comb begin : fshift_check
      fshift_need = 1'b0;
      for (int i = 0; i < 6; i++) begin
         if (dmag_ff[i][32:30] != '0) fshift_need = 1'b1;
      end
   end

   always_comb begin : corner_sel
      case (k_ff)
         2'd0:    corner = a_ff;
         2'd1:    corner = b_ff;
         default: corner = c_ff;
      endcase
   end

   // sequencer next state
   always_comb begin : seq_next
      state_in = state_ff;
      unique case (state_ff)
         T_CLEAR: if (clr_ff == AW'(VERTS - 1)) state_in = T_IDLE;
         T_IDLE: begin
            if (req_fire) begin
               unique case (req_if.data.mode)
                  MODE_TRI:  if (tri_ok) state_in = T_PB;
                  MODE_READ: state_in = a_ok ? T_USTART : T_PUT;
                  default:   ;
               endcase
            end
         end
         T_PB:     state_in = T_PC;
         T_PC:     state_in = T_PD;
         T_PD:     state_in = T_FSHIFT;
         T_FSHIFT: if (!fshift_need) state_in = T_CROSS;
         T_CROSS:  if (step_ff == CROSS_LAST) state_in = T_USTART;
         T_USTART: state_in = T_NWAIT;
         T_NWAIT: begin
            if (ustat.done) begin
               if (is_read_ff) state_in = T_PUT;
               else state_in = ustat.ok ? T_ARD : T_IDLE;
            end
         end
         T_ARD:    state_in = T_AWR;
         T_AWR:    if (k_ff == 2'd2) state_in = T_IDLE;
                   else state_in = T_ARD;
         T_PUT:    if (out_free) state_in = T_IDLE;
         default:  state_in = T_IDLE;
      endcase
   end

   // sequencer outputs and datapath
   always_comb begin : seq_out
      logic signed [32:0] d;
      req_if.ready = (state_ff == T_IDLE);
      clr_in     = clr_ff;
      a_in       = a_ff;
      b_in       = b_ff;
      c_in       = c_ff;
      is_read_in = is_read_ff;
      bad_in     = bad_ff;
      pa_in      = pa_ff;
      dmag_in    = dmag_ff;
      dneg_in    = dneg_ff;
      prod_in    = prod_ff;
      cr_in      = cr_ff;
      step_in    = step_ff;
      k_in       = k_ff;
      rsp_in     = rsp_ff;
      out_load   = 1'b0;
      pos_we     = 1'b0;
      pos_re     = 1'b0;
      sum_we     = 1'b0;
      sum_re     = 1'b0;
      pos_wa     = AW'(req_if.data.vertex_index);
      pos_ra     = AW'(req_if.data.vertex_index);
      sum_wa     = corner;
      sum_ra     = corner;
      sum_wd     = '0;
      ustart     = 1'b0;
      d          = '0;
      unique case (state_ff)
         T_CLEAR: begin
            sum_we = 1'b1;
            sum_wa = clr_ff;
            clr_in = clr_ff + AW'(1);
         end
         T_IDLE: begin
            if (req_fire) begin
               a_in = AW'(req_if.data.vertex_index);
               b_in = AW'(req_if.data.corner_b);
               c_in = AW'(req_if.data.corner_c);
               is_read_in = (req_if.data.mode == MODE_READ);
               bad_in = !a_ok;
               unique case (req_if.data.mode)
                  MODE_LOAD: begin
                     // store the position and restart its sum
                     pos_we = a_ok;
                     sum_we = a_ok;
                     sum_wa = AW'(req_if.data.vertex_index);
                  end
                  MODE_TRI: pos_re = tri_ok;
                  MODE_READ: begin
                     sum_re = a_ok;
                     sum_ra = AW'(req_if.data.vertex_index);
                  end
                  default: ;
               endcase
            end
         end
         T_PB: begin
            pos_re = 1'b1;
            pos_ra = b_ff;
            pa_in  = pos_rd_ff;
         end
         T_PC: begin
            pos_re = 1'b1;
            pos_ra = c_ff;
            for (int i = 0; i < 3; i++) begin
               d = 33'(signed'(pos_rd_ff[32*i +: 32])) - 33'(signed'(pa_ff[32*i +: 32]));
               dneg_in[i] = d[32];
               dmag_in[i] = d[32] ? 33'(-d) : 33'(d);
            end
         end
         T_PD: begin
            for (int i = 0; i < 3; i++) begin
               d = 33'(signed'(pos_rd_ff[32*i +: 32])) - 33'(signed'(pa_ff[32*i +: 32]));
               dneg_in[i+3] = d[32];
               dmag_in[i+3] = d[32] ? 33'(-d) : 33'(d);
            end
         end
         T_FSHIFT: begin
            // bring every component of both edge vectors below 2^30 together
            if (fshift_need) begin
               for (int i = 0; i < 6; i++) dmag_in[i] = dmag_ff[i] >> 1;
            end else begin
               step_in = 3'd0;
               for (int i = 0; i < 3; i++) cr_in[i] = '0;
            end
         end
         T_CROSS: begin
            // one product per step, folded into its component a step later
            step_in = step_ff + 3'd1;
            case (step_ff)
               3'd0: prod_in = dval(dmag_ff[1], dneg_ff[1]) * dval(dmag_ff[5], dneg_ff[5]);
               3'd1: begin
                  prod_in  = dval(dmag_ff[2], dneg_ff[2]) * dval(dmag_ff[4], dneg_ff[4]);
                  cr_in[0] = cr_ff[0] + CW'(prod_ff);
               end
               3'd2: begin
                  prod_in  = dval(dmag_ff[2], dneg_ff[2]) * dval(dmag_ff[3], dneg_ff[3]);
                  cr_in[0] = cr_ff[0] - CW'(prod_ff);
               end
               3'd3: begin
                  prod_in  = dval(dmag_ff[0], dneg_ff[0]) * dval(dmag_ff[5], dneg_ff[5]);
                  cr_in[1] = cr_ff[1] + CW'(prod_ff);
               end
               3'd4: begin
                  prod_in  = dval(dmag_ff[0], dneg_ff[0]) * dval(dmag_ff[4], dneg_ff[4]);
                  cr_in[1] = cr_ff[1] - CW'(prod_ff);
               end
               3'd5: begin
                  prod_in  = dval(dmag_ff[1], dneg_ff[1]) * dval(dmag_ff[3], dneg_ff[3]);
                  cr_in[2] = cr_ff[2] + CW'(prod_ff);
               end
               default: cr_in[2] = cr_ff[2] - CW'(prod_ff);
            endcase
         end
         T_USTART: ustart = 1'b1;
         T_NWAIT:  k_in = 2'd0;
         T_ARD:    sum_re = 1'b1;
         T_AWR: begin
            // write back one corner; the next read waits, so repeats see this sum
            sum_we = 1'b1;
            sum_wd = {sat_add(sum_rd_ff[71:48], nz),
                      sat_add(sum_rd_ff[47:24], ny),
                      sat_add(sum_rd_ff[23:0], nx)};
            k_in   = k_ff + 2'd1;
         end
         T_PUT: begin
            if (out_free) begin
               out_load = 1'b1;
               rsp_in.normal_x    = bad_ff ? '0 : nx;
               rsp_in.normal_y    = bad_ff ? '0 : ny;
               rsp_in.normal_z    = bad_ff ? '0 : nz;
               rsp_in.zero_normal = bad_ff || !ustat.ok;
            end
         end
         default: ;
      endcase
   end

   assign rsp_valid_in = out_load || (rsp_valid_ff && !rsp_if.ready);

   // normalizer input: the read sum or the face cross product
   assign ux = is_read_ff ? CW'(signed'(sum_rd_ff[23:0]))  : cr_ff[0];
   assign uy = is_read_ff ? CW'(signed'(sum_rd_ff[47:24])) : cr_ff[1];
   assign uz = is_read_ff ? CW'(signed'(sum_rd_ff[71:48])) : cr_ff[2];

   svn_unit3 u_unit3 (
      .clock (clock),
      .reset (reset),
      .start (ustart),
      .vec_x (ux),
      .vec_y (uy),
      .vec_z (uz),
      .nrm_x (nx),
      .nrm_y (ny),
      .nrm_z (nz),
      .stat  (ustat)
   );

   always_ff @(posedge clock) begin : pos_store
      if (pos_we) begin
         pos_mem_ff[pos_wa] <= {req_if.data.pos_z, req_if.data.pos_y, req_if.data.pos_x};
      end
      if (pos_re) pos_rd_ff <= pos_mem_ff[pos_ra];
   end

   always_ff @(posedge clock) begin : sum_store
      if (sum_we) sum_mem_ff[sum_wa] <= sum_wd;
      if (sum_re) sum_rd_ff <= sum_mem_ff[sum_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff       <= a_in;
      b_ff       <= b_in;
      c_ff       <= c_in;
      is_read_ff <= is_read_in;
      bad_ff     <= bad_in;
      pa_ff      <= pa_in;
      dmag_ff    <= dmag_in;
      dneg_ff    <= dneg_in;
      prod_ff    <= prod_in;
      cr_ff      <= cr_in;
      step_ff    <= step_in;
      k_ff       <= k_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.data  = rsp_ff;

   `SVN_ASSERT_NOW(a_acc_corner, (sum_we && state_ff == T_AWR), (sum_wa == a_ff || sum_wa == b_ff || sum_wa == c_ff), "sum write-back off the triangle corners")
   `SVN_ASSERT_NOW(a_out_free, out_load, (!rsp_valid_ff || rsp_if.ready), "response register overwritten")
   `SVN_ASSERT_NOW(a_unit_idle, ustart, !ustat.busy, "normalizer started while busy")
   `SVN_ASSERT_NEXT(a_unit_runs, ustart, ustat.busy, "normalizer ignored start")

endmodule

@@ verif/tb.sv @@
// Self-checking testbench for the smooth vertex normals block.
`timescale 1ns / 100ps

module tb;
   import svn_pkg::*;

   // no package name exists for the spare mode, which the block must ignore
   localparam logic [1:0] MODE_SPARE = 2'd3;
   localparam int         NVERT      = 1024;
   localparam int         ITEM_GOAL  = 1200;
   localparam int         CYCLE_CAP  = 3000000;
   localparam int         LONG_HOLD  = 3000;
   localparam int         TAIL       = 200;
   localparam longint     SUM_HI     = 8388607;
   localparam longint     SUM_LO     = -8388608;

   typedef longint vec3_type[3];

   // Keeps its own copy of positions and normal sums, works out the normal
   // that each read must return, and checks the returned normals in order.
   class vertex_normal_tracker;
      longint   pos_x[NVERT], pos_y[NVERT], pos_z[NVERT];
      longint   sum_x[NVERT], sum_y[NVERT], sum_z[NVERT];
      rsp_type  pending_normals[$];
      int       errors, checked, zero_reads, faces_added, flat_faces;
      int       loads, triangles, reads, ignored;

      function new();
         for (int i = 0; i < NVERT; i++) begin
            pos_x[i] = 0; pos_y[i] = 0; pos_z[i] = 0;
            sum_x[i] = 0; sum_y[i] = 0; sum_z[i] = 0;
         end
      endfunction

      task report_mismatch(input string what, input int got, input int want);
         errors++;
         $display("MISMATCH %s: got %0d, expected %0d (normal %0d)", what, got, want, checked);
      endtask

      function bit [63:0] int_sqrt(input bit [63:0] v);
         bit [63:0] r, b;
         r = 0;
         b = 64'd1 << 62;
         while (b > v) b >>= 2;
         while (b != 0) begin
            if (v >= r + b) begin
               v = v - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b >>= 2;
         end
         return r;
      endfunction

      // scale the magnitudes so the largest lies in [2^29, 2^30), then divide by the rounded-down length
      function bit to_unit(input vec3_type v, output vec3_type o);
         bit [63:0] m[3];
         bit [63:0] mx, s, len, q;
         mx = 0;
         s  = 0;
         for (int i = 0; i < 3; i++) begin
            m[i] = v[i] < 0 ? -v[i] : v[i];
            if (m[i] > mx) mx = m[i];
            o[i] = 0;
         end
         if (mx == 0) return 0;
         while (mx >= (64'd1 << 30)) begin
            for (int i = 0; i < 3; i++) m[i] >>= 1;
            mx >>= 1;
         end
         while (mx < (64'd1 << 29)) begin
            for (int i = 0; i < 3; i++) m[i] <<= 1;
            mx <<= 1;
         end
         for (int i = 0; i < 3; i++) s += m[i] * m[i];
         len = int_sqrt(s);
         for (int i = 0; i < 3; i++) begin
            q = (m[i] * 64'd16384 + len / 2) / len;
            o[i] = v[i] < 0 ? -longint'(q) : longint'(q);
         end
         return 1;
      endfunction

      function longint clamp_sum(input longint acc, input longint n);
         longint s;
         s = acc + n;
         if (s > SUM_HI) s = SUM_HI;
         if (s < SUM_LO) s = SUM_LO;
         return s;
      endfunction

      function void add_face(input int a, input int b, input int c);
         longint    d[6];
         bit [63:0] mg[6];
         bit [63:0] mx;
         vec3_type  cr, n;
         int        corner[3];
         d[0] = pos_x[b] - pos_x[a];
         d[1] = pos_y[b] - pos_y[a];
         d[2] = pos_z[b] - pos_z[a];
         d[3] = pos_x[c] - pos_x[a];
         d[4] = pos_y[c] - pos_y[a];
         d[5] = pos_z[c] - pos_z[a];
         mx = 0;
         for (int i = 0; i < 6; i++) begin
            mg[i] = d[i] < 0 ? -d[i] : d[i];
            if (mg[i] > mx) mx = mg[i];
         end
         // truncate the edge vectors together so the cross product stays exact
         while (mx >= (64'd1 << 30)) begin
            for (int i = 0; i < 6; i++) mg[i] >>= 1;
            mx >>= 1;
         end
         for (int i = 0; i < 6; i++) d[i] = d[i] < 0 ? -longint'(mg[i]) : longint'(mg[i]);
         cr[0] = d[1] * d[5] - d[2] * d[4];
         cr[1] = d[2] * d[3] - d[0] * d[5];
         cr[2] = d[0] * d[4] - d[1] * d[3];
         if (!to_unit(cr, n)) begin
            flat_faces++;
            return;
         end
         faces_added++;
         corner[0] = a; corner[1] = b; corner[2] = c;
         foreach (corner[k]) begin
            sum_x[corner[k]] = clamp_sum(sum_x[corner[k]], n[0]);
            sum_y[corner[k]] = clamp_sum(sum_y[corner[k]], n[1]);
            sum_z[corner[k]] = clamp_sum(sum_z[corner[k]], n[2]);
         end
      endfunction

      function void note_request(input req_type r);
         vec3_type v, n;
         rsp_type  e;
         bit       ok;
         case (r.mode)
            MODE_LOAD: begin
               loads++;
               pos_x[r.vertex_index] = r.pos_x;
               pos_y[r.vertex_index] = r.pos_y;
               pos_z[r.vertex_index] = r.pos_z;
               sum_x[r.vertex_index] = 0;
               sum_y[r.vertex_index] = 0;
               sum_z[r.vertex_index] = 0;
            end
            MODE_TRI: begin
               triangles++;
               add_face(r.vertex_index, r.corner_b, r.corner_c);
            end
            MODE_READ: begin
               reads++;
               v[0] = sum_x[r.vertex_index];
               v[1] = sum_y[r.vertex_index];
               v[2] = sum_z[r.vertex_index];
               ok = to_unit(v, n);
               e.normal_x    = 16'(n[0]);
               e.normal_y    = 16'(n[1]);
               e.normal_z    = 16'(n[2]);
               e.zero_normal = !ok;
               pending_normals.push_back(e);
            end
            default: ignored++;
         endcase
      endfunction

      task check_normal(input rsp_type got);
         rsp_type want;
         if (pending_normals.size() == 0) begin
            report_mismatch("unexpected normal", got.normal_x, 0);
            return;
         end
         want = pending_normals.pop_front();
         checked++;
         if (want.zero_normal) zero_reads++;
         if (got.normal_x !== want.normal_x) report_mismatch("normal_x", got.normal_x, want.normal_x);
         if (got.normal_y !== want.normal_y) report_mismatch("normal_y", got.normal_y, want.normal_y);
         if (got.normal_z !== want.normal_z) report_mismatch("normal_z", got.normal_z, want.normal_z);
         if (got.zero_normal !== want.zero_normal)
            report_mismatch("zero_normal", got.zero_normal, want.zero_normal);
      endtask
   endclass

   logic clock;
   logic reset;

   svn_req_if req_if ();
   svn_rsp_if rsp_if ();

   smooth_vertex_normals #(.VERTS(NVERT)) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   vertex_normal_tracker tracker = new();

   int  cycles;
   int  items;
   int  burst_left;
   bit  hold_request;
   bit  loaded[NVERT];

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // Drive every input to a known value before the first edge.
   initial begin
      reset         = 1'b1;
      req_if.valid  = 1'b0;
      req_if.data   = '0;
      rsp_if.ready  = 1'b0;
      hold_request  = 1'b0;
   end

   // Watchdog: a hung block ends the run here.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_CAP) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Note each accepted request and check each accepted normal at the rising edge.
   always @(posedge clock) begin
      if (!reset && req_if.valid && req_if.ready) tracker.note_request(req_if.data);
      if (!reset && rsp_if.valid && rsp_if.ready) tracker.check_normal(rsp_if.data);
   end

   // Receiver: switch among stall styles now and then; on request, hold off
   // for a long stretch so the block fills up and stalls its input.
   int ready_style, style_left, hold_left;
   always @(negedge clock) begin
      if (hold_request && hold_left == 0) begin
         hold_left    = LONG_HOLD;
         hold_request = 1'b0;
      end
      if (style_left == 0) begin
         ready_style = $urandom_range(0, 3);
         style_left  = $urandom_range(50, 300);
      end else begin
         style_left--;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_if.ready <= 1'b0;
      end else begin
         case (ready_style)
            0:       rsp_if.ready <= 1'b1;
            1:       rsp_if.ready <= $urandom_range(0, 1);
            2:       rsp_if.ready <= (cycles % 4 == 0);
            default: rsp_if.ready <= ($urandom_range(0, 9) != 0);
         endcase
      end
   end

   // Offer one request; start a new burst after a random gap when the last one ran out.
   task automatic put(input req_type r);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 20);
         if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      req_if.valid <= 1'b1;
      req_if.data  <= r;
      do @(posedge clock); while (!req_if.ready);
      @(negedge clock);
      items++;
   endtask

   task automatic load_vertex(input int idx, input int px, input int py, input int pz);
      req_type r;
      r              = req_type'({$urandom(), $urandom(), $urandom(), $urandom()});
      r.mode         = MODE_LOAD;
      r.vertex_index = idx;
      r.pos_x        = px;
      r.pos_y        = py;
      r.pos_z        = pz;
      loaded[idx]    = 1'b1;
      put(r);
   endtask

   task automatic add_triangle(input int a, input int b, input int c);
      req_type r;
      r              = req_type'({$urandom(), $urandom(), $urandom(), $urandom()});
      r.mode         = MODE_TRI;
      r.vertex_index = a;
      r.corner_b     = b;
      r.corner_c     = c;
      put(r);
   endtask

   task automatic read_normal(input int idx);
      req_type r;
      r              = req_type'({$urandom(), $urandom(), $urandom(), $urandom()});
      r.mode         = MODE_READ;
      r.vertex_index = idx;
      put(r);
   endtask

   // Hold the sender until every expected normal has come back.
   task automatic drain();
      req_if.valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (tracker.pending_normals.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // Random coordinate at one of three scales, so both the plain cross
   // product and the truncating range shift get exercised.
   function automatic int rand_coord(input int scale);
      case (scale)
         0:       return int'($urandom_range(0, 8191)) - 4096;
         1:       return int'($urandom_range(0, 32'h3FFFFF)) - 32'h200000;
         default: return int'($urandom());
      endcase
   endfunction

   // One small mesh patch: load a few vertices, stitch triangles among them,
   // then read back the normals of some of them.
   task automatic run_patch();
      int k, scale, tris;
      int idx[6];
      k     = $urandom_range(3, 6);
      scale = $urandom_range(0, 2);
      for (int i = 0; i < k; i++) begin
         idx[i] = $urandom_range(0, NVERT - 1);
         load_vertex(idx[i], rand_coord(scale), rand_coord(scale), rand_coord(scale));
      end
      tris = $urandom_range(k, 2 * k);
      for (int i = 0; i < tris; i++)
         add_triangle(idx[$urandom_range(0, k - 1)], idx[$urandom_range(0, k - 1)],
                      idx[$urandom_range(0, k - 1)]);
      for (int i = 0; i < k; i++)
         if ($urandom_range(0, 3) != 0) read_normal(idx[i]);
   endtask

   // Noise: spare mode, reads anywhere, triangles over already loaded vertices.
   task automatic run_noise();
      req_type r;
      int      a, b, c;
      case ($urandom_range(0, 2))
         0: begin
            r      = req_type'({$urandom(), $urandom(), $urandom(), $urandom()});
            r.mode = MODE_SPARE;
            put(r);
         end
         1: read_normal($urandom_range(0, NVERT - 1));
         default: begin
            a = $urandom_range(0, NVERT - 1);
            b = $urandom_range(0, NVERT - 1);
            c = $urandom_range(0, NVERT - 1);
            // never touch a position that was not loaded
            if (loaded[a] && loaded[b] && loaded[c]) add_triangle(a, b, c);
            else read_normal(a);
         end
      endcase
   endtask

   initial begin
      req_type r;
      bit      held, paused;
      items      = 0;
      burst_left = 0;
      held       = 1'b0;
      paused     = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part: zero sum, unit triangle and its reverse, extreme
      // positions that force the range shift, flat faces, spare mode.
      read_normal(5);
      load_vertex(0, 0, 0, 0);
      load_vertex(1, 32'h10000, 0, 0);
      load_vertex(2, 0, 32'h10000, 0);
      add_triangle(0, 1, 2);
      read_normal(0);
      add_triangle(0, 2, 1);
      read_normal(1);
      load_vertex(1023, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
      load_vertex(1022, 32'h80000000, 32'h7FFFFFFF, 32'h80000000);
      add_triangle(0, 1023, 1022);
      read_normal(1023);
      read_normal(1022);
      add_triangle(0, 0, 1);
      load_vertex(3, 32'h20000, 0, 0);
      add_triangle(0, 1, 3);
      read_normal(3);
      r      = '1;
      r.mode = MODE_SPARE;
      put(r);
      read_normal(0);
      drain();

      // Drive one triangle's corners into saturation, then back off it.
      load_vertex(100, 0, 0, 0);
      load_vertex(101, 32'h10000, 0, 0);
      load_vertex(102, 0, 32'h10000, 0);
      repeat (530) add_triangle(100, 101, 102);
      read_normal(100);
      repeat (5) add_triangle(100, 102, 101);
      read_normal(101);
      drain();

      // Random part: mostly mesh patches, some noise.
      while (items < ITEM_GOAL) begin
         if ($urandom_range(0, 9) < 8) run_patch();
         else run_noise();
         if (!held && items > 800) begin
            hold_request = 1'b1;
            held         = 1'b1;
         end
         if (!paused && items > 1000) begin
            drain();
            paused = 1'b1;
         end
      end

      req_if.valid <= 1'b0;
      @(posedge clock);
      while (tracker.pending_normals.size() != 0) @(posedge clock);
      repeat (TAIL) @(posedge clock);

      if (tracker.pending_normals.size() != 0)
         tracker.report_mismatch("normals never returned", 0, tracker.pending_normals.size());
      $display("Covered %0d loads, %0d triangles (%0d flat), %0d reads, %0d spare-mode requests.",
               tracker.loads, tracker.triangles, tracker.flat_faces, tracker.reads,
               tracker.ignored);
      $display("Checked %0d normals, %0d of them zero sums; %0d mismatches.",
               tracker.checked, tracker.zero_reads, tracker.errors);
      if (tracker.errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

@@ smooth_vertex_normals.f @@
+incdir+rtl
rtl/svn_pkg.sv
rtl/svn_req_if.sv
rtl/svn_rsp_if.sv
rtl/svn_unit3.sv
rtl/smooth_vertex_normals.sv
verif/tb.sv
